/* rtl/pgvu_pkg.sv */
// Shared types, widths and step functions for the gravity velocity update pipeline.
`default_nettype none

package pgvu_pkg;

  // field and datapath widths
  localparam int POS_W    = 24;
  localparam int VEL_W    = 24;
  localparam int MASS_W   = 16;
  localparam int GRAV_W   = 16;
  localparam int MIND_W   = 23;
  localparam int OFF_W    = 25;
  localparam int R2_W     = 50;
  localparam int ROOT_W   = 25;
  localparam int SQREM_W  = 26;
  localparam int GM_W     = 32;
  localparam int NUM_W    = 57;
  localparam int DEN_W    = 75;
  localparam int Q_W      = 25;
  localparam int NV_W     = 26;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 23;

  // latencies of the root and divide pipelines
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT  = Q_W + 1;
  localparam int PIPE_LAT = 3 + SQRT_LAT + 3 + DIV_LAT + 1;

  localparam logic [Q_W-1:0]    DELTA_CAP  = Q_W'(1) << (Q_W - 1);
  localparam logic [GRAV_W-1:0] GRAV_RESET = GRAV_W'(2560);
  localparam logic [MIND_W-1:0] MIND_RESET = MIND_W'(3840);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAVITY  = 2'd0,
    REG_MIN_DIST = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [POS_W-1:0] body_x;
    logic signed [POS_W-1:0] body_y;
    logic signed [VEL_W-1:0] body_vx;
    logic signed [VEL_W-1:0] body_vy;
    logic [MASS_W-1:0]       body_mass;
    logic signed [POS_W-1:0] planet_x;
    logic signed [POS_W-1:0] planet_y;
    logic [MASS_W-1:0]       planet_mass;
  } in_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] new_vx;
    logic signed [VEL_W-1:0] new_vy;
    logic                    applied;
  } out_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  q;
    logic [SQREM_W-1:0] rem;
  } sq_t;

  typedef struct packed {
    logic             bit_q;
    logic [DEN_W-1:0] rem;
  } dv_t;

  // one digit of the integer square root
  function automatic sq_t sqrt_step(input logic [ROOT_W-1:0] q,
                                    input logic [SQREM_W-1:0] rem,
                                    input logic [1:0] pair);
    logic [SQREM_W+1:0] cur;
    logic [SQREM_W+1:0] trial;
    sq_t r;
    cur   = {rem, pair};
    trial = {1'b0, q, 2'b01};
    if (cur >= trial) begin
      r.rem = SQREM_W'(cur - trial);
      r.q   = {q[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem = cur[SQREM_W-1:0];
      r.q   = {q[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of the restoring divide
  function automatic dv_t div_step(input logic [DEN_W-1:0] rem,
                                   input logic [DEN_W-1:0] den,
                                   input logic nbit);
    logic [DEN_W:0] cur;
    dv_t r;
    cur = {rem, nbit};
    if (cur >= {1'b0, den}) begin
      r.rem   = DEN_W'(cur - {1'b0, den});
      r.bit_q = 1'b1;
    end else begin
      r.rem   = cur[DEN_W-1:0];
      r.bit_q = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/pgvu_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module pgvu_sqrt (
  input  wire logic                         clk,
  input  wire logic [pgvu_pkg::R2_W-1:0]    r2_i,
  output logic      [pgvu_pkg::ROOT_W-1:0]  root_o
);
  import pgvu_pkg::*;

  logic [ROOT_W-1:0]  q_r   [0:ROOT_W-1];
  logic [SQREM_W-1:0] rem_r [0:ROOT_W-1];
  logic [R2_W-1:0]    x_r   [0:ROOT_W-1];

  // first digit from the top bit pair
  sq_t st0;
  always_comb begin
    st0 = sqrt_step('0, '0, r2_i[R2_W-1 -: 2]);
  end

  always_ff @(posedge clk) begin
    q_r[0]   <= st0.q;
    rem_r[0] <= st0.rem;
    x_r[0]   <= r2_i << 2;
  end

  // remaining digits, one pair per stage
  genvar i;
  generate
    for (i = 1; i < ROOT_W; i++) begin : g_stage
      sq_t st;
      always_comb begin
        st = sqrt_step(q_r[i-1], rem_r[i-1], x_r[i-1][R2_W-1 -: 2]);
      end
      always_ff @(posedge clk) begin
        q_r[i]   <= st.q;
        rem_r[i] <= st.rem;
        x_r[i]   <= x_r[i-1] << 2;
      end
    end
  endgenerate

  assign root_o = q_r[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/pgvu_div.sv */
// Pipelined restoring divide of (num * 2^24) by den, quotient clamped to the delta cap.
`default_nettype none

module pgvu_div (
  input  wire logic                        clk,
  input  wire logic [pgvu_pkg::NUM_W-1:0]  num_i,
  input  wire logic [pgvu_pkg::DEN_W-1:0]  den_i,
  output logic      [pgvu_pkg::Q_W-1:0]    q_o
);
  import pgvu_pkg::*;

  logic [DEN_W-1:0] rem_r  [0:Q_W];
  logic [DEN_W-1:0] den_r  [0:Q_W];
  logic [Q_W-1:0]   bits_r [0:Q_W];
  logic [Q_W-1:0]   q_r    [0:Q_W];
  logic             ovf_r  [0:Q_W];

  // flag quotients of 2^25 or more, load the high part of the dividend
  always_ff @(posedge clk) begin
    ovf_r[0]  <= ({(DEN_W+1-NUM_W)'(0), num_i} >= {den_i, 1'b0});
    rem_r[0]  <= DEN_W'(num_i[NUM_W-1:1]);
    bits_r[0] <= {num_i[0], (Q_W-1)'(0)};
    q_r[0]    <= '0;
    den_r[0]  <= den_i;
  end

  // one quotient bit per stage
  genvar i;
  generate
    for (i = 1; i <= Q_W; i++) begin : g_stage
      dv_t st;
      always_comb begin
        st = div_step(rem_r[i-1], den_r[i-1], bits_r[i-1][Q_W-1]);
      end
      always_ff @(posedge clk) begin
        rem_r[i]  <= st.rem;
        bits_r[i] <= bits_r[i-1] << 1;
        q_r[i]    <= {q_r[i-1][Q_W-2:0], st.bit_q};
        den_r[i]  <= den_r[i-1];
        ovf_r[i]  <= ovf_r[i-1];
      end
    end
  endgenerate

  // clamp to the cap
  always_comb begin
    if (ovf_r[Q_W] || (q_r[Q_W] > DELTA_CAP)) begin
      q_o = DELTA_CAP;
    end else begin
      q_o = q_r[Q_W];
    end
  end

endmodule

`default_nettype wire

/* rtl/planet_gravity_velocity_update.sv */
// Throughput: one word per cycle while busy is low; root and divide are fully pipelined,
// one bit per stage.
// Reset: synchronous, active low; clears the valid chain and loads G = 10.0 and
// minimum distance = 15.0. busy is high during reset and until the first edge after it;
// results cannot be stalled.
`default_nettype none

module planet_gravity_velocity_update (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire pgvu_pkg::in_t                   in_data,
  output logic                                 out_valid,
  output pgvu_pkg::out_t                       out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pgvu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pgvu_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import pgvu_pkg::*;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                    sx;
    logic                    sy;
    logic [OFF_W-1:0]        adx;
    logic [OFF_W-1:0]        ady;
    logic [GM_W-1:0]         gm;
    logic                    mass0;
  } side_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic                    sx;
    logic                    sy;
    logic                    skip;
  } fin_t;

  logic              busy_r;
  logic [GRAV_W-1:0] grav_r;
  logic [MIND_W-1:0] mind_r;
  logic [PIPE_LAT-1:0] vld_r;
  logic              accept;

  // hold busy through reset, take config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      grav_r <= GRAV_RESET;
      mind_r <= MIND_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GRAVITY:  grav_r <= cfg_data[GRAV_W-1:0];
          REG_MIN_DIST: mind_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy_r;

  // advance the valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], accept};
    end
  end

  // stage 0: offsets and their magnitudes
  logic signed [OFF_W-1:0] dx, dy;
  side_t s0_nxt, s0_r;
  logic [MASS_W-1:0] pm0_r;
  always_comb begin
    dx = OFF_W'(in_data.planet_x) - OFF_W'(in_data.body_x);
    dy = OFF_W'(in_data.planet_y) - OFF_W'(in_data.body_y);
    s0_nxt.vx    = in_data.body_vx;
    s0_nxt.vy    = in_data.body_vy;
    s0_nxt.sx    = dx[OFF_W-1];
    s0_nxt.sy    = dy[OFF_W-1];
    s0_nxt.adx   = dx[OFF_W-1] ? OFF_W'(-dx) : OFF_W'(dx);
    s0_nxt.ady   = dy[OFF_W-1] ? OFF_W'(-dy) : OFF_W'(dy);
    s0_nxt.gm    = '0;
    s0_nxt.mass0 = (in_data.body_mass == '0);
  end

  always_ff @(posedge clk) begin
    s0_r  <= s0_nxt;
    pm0_r <= in_data.planet_mass;
  end

  // stage 1: squares and G * planet mass
  side_t s1_nxt, s1_r;
  logic [R2_W-1:0] sqx_r, sqy_r;
  always_comb begin
    s1_nxt    = s0_r;
    s1_nxt.gm = grav_r * pm0_r;
  end

  always_ff @(posedge clk) begin
    sqx_r <= s0_r.adx * s0_r.adx;
    sqy_r <= s0_r.ady * s0_r.ady;
    s1_r  <= s1_nxt;
  end

  // stage 2: squared distance
  side_t s2_r;
  logic [R2_W-1:0] r2_r;
  always_ff @(posedge clk) begin
    r2_r <= sqx_r + sqy_r;
    s2_r <= s1_r;
  end

  // root pipeline with matching sideband delay
  logic [ROOT_W-1:0] root;
  side_t sd_r [0:SQRT_LAT-1];

  pgvu_sqrt u_sqrt (
    .clk    (clk),
    .r2_i   (r2_r),
    .root_o (root)
  );

  always_ff @(posedge clk) begin
    sd_r[0] <= s2_r;
    for (int k = 1; k < SQRT_LAT; k++) begin
      sd_r[k] <= sd_r[k-1];
    end
  end

  // M1: r^2, numerators and the skip test
  side_t sq;
  fin_t m1_nxt, m1_r, m2_r, m3_r;
  logic [R2_W-1:0]   rr_r;
  logic [ROOT_W-1:0] root1_r;
  logic [NUM_W-1:0]  numx1_r, numy1_r, numx2_r, numy2_r, numx3_r, numy3_r;
  always_comb begin
    sq          = sd_r[SQRT_LAT-1];
    m1_nxt.vx   = sq.vx;
    m1_nxt.vy   = sq.vy;
    m1_nxt.sx   = sq.sx;
    m1_nxt.sy   = sq.sy;
    m1_nxt.skip = sq.mass0 || (root == '0) || (root < ROOT_W'(mind_r));
  end

  always_ff @(posedge clk) begin
    rr_r    <= root * root;
    root1_r <= root;
    numx1_r <= sq.gm * sq.adx;
    numy1_r <= sq.gm * sq.ady;
    m1_r    <= m1_nxt;
  end

  // M2: split product r^2 * r
  logic [R2_W-1:0] denhi_r, denlo_r;
  always_ff @(posedge clk) begin
    denhi_r <= rr_r[R2_W-1:ROOT_W] * root1_r;
    denlo_r <= rr_r[ROOT_W-1:0] * root1_r;
    numx2_r <= numx1_r;
    numy2_r <= numy1_r;
    m2_r    <= m1_r;
  end

  // M3: combine into r^3
  logic [DEN_W-1:0] den_r;
  always_ff @(posedge clk) begin
    den_r   <= {denhi_r, ROOT_W'(0)} + DEN_W'(denlo_r);
    numx3_r <= numx2_r;
    numy3_r <= numy2_r;
    m3_r    <= m2_r;
  end

  // divide per axis with matching sideband delay
  logic [Q_W-1:0] qx, qy;
  fin_t fd_r [0:DIV_LAT-1];

  pgvu_div u_div_x (
    .clk   (clk),
    .num_i (numx3_r),
    .den_i (den_r),
    .q_o   (qx)
  );

  pgvu_div u_div_y (
    .clk   (clk),
    .num_i (numy3_r),
    .den_i (den_r),
    .q_o   (qy)
  );

  always_ff @(posedge clk) begin
    fd_r[0] <= m3_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      fd_r[k] <= fd_r[k-1];
    end
  end

  // output: apply delta, saturate, or pass velocity through
  fin_t fo;
  logic signed [NV_W-1:0] nvx, nvy;
  out_t out_nxt, out_r;

  function automatic logic [VEL_W-1:0] sat_vel(input logic signed [NV_W-1:0] v);
    logic [VEL_W-1:0] r;
    if (v[NV_W-1:VEL_W-1] == '0 || v[NV_W-1:VEL_W-1] == '1) begin
      r = v[VEL_W-1:0];
    end else if (v[NV_W-1]) begin
      r = {1'b1, (VEL_W-1)'(0)};
    end else begin
      r = {1'b0, {(VEL_W-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    fo  = fd_r[DIV_LAT-1];
    nvx = fo.sx ? (NV_W'(fo.vx) - $signed(NV_W'(qx))) : (NV_W'(fo.vx) + $signed(NV_W'(qx)));
    nvy = fo.sy ? (NV_W'(fo.vy) - $signed(NV_W'(qy))) : (NV_W'(fo.vy) + $signed(NV_W'(qy)));
    if (fo.skip) begin
      out_nxt.new_vx  = fo.vx;
      out_nxt.new_vy  = fo.vy;
      out_nxt.applied = 1'b0;
    end else begin
      out_nxt.new_vx  = sat_vel(nvx);
      out_nxt.new_vy  = sat_vel(nvy);
      out_nxt.applied = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_data  = out_r;

endmodule

`default_nettype wire

/* verif/testbench.sv */
// Self-checking testbench for the planet gravity velocity update pipeline.
`default_nettype none

module testbench;
  import pgvu_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = PIPE_LAT + 20;
  localparam int IN_W = $bits(in_t);

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t in_data;
  logic out_valid;
  out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  planet_gravity_velocity_update i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic [GRAV_W-1:0] model_grav;
  logic [MIND_W-1:0] model_min_dist;

  in_t pair_q[$];
  out_t velocity_q[$];
  int mismatches;
  int pairs_sent;
  int pulls_applied;
  int idle_cycles;
  int burst_left;
  int gap_left;

  // integer square root, floor
  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int i = 25; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // new velocity on one axis: v + sign(d) * min(cap, g*m*|d|*2^24 / r^3), saturated
  function automatic logic [VEL_W-1:0] axis_velocity(logic signed [VEL_W-1:0] v,
                                                     logic signed [OFF_W-1:0] d,
                                                     logic [63:0] gm,
                                                     logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] num;
    logic [127:0] quo;
    longint nv;
    mag = d < 0 ? 128'(-d) : 128'(d);
    num = (128'(gm) * mag) << 24;
    quo = num / den;
    if (quo > 128'(DELTA_CAP)) quo = 128'(DELTA_CAP);
    nv = d < 0 ? longint'(v) - longint'(quo) : longint'(v) + longint'(quo);
    if (nv > 8388607) nv = 8388607;
    if (nv < -8388608) nv = -8388608;
    return nv[VEL_W-1:0];
  endfunction

  function automatic out_t pulled_velocity(in_t w);
    logic signed [OFF_W-1:0] dx;
    logic signed [OFF_W-1:0] dy;
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] rt;
    logic [63:0] gm;
    logic [127:0] den;
    out_t r;
    dx = OFF_W'(w.planet_x) - OFF_W'(w.body_x);
    dy = OFF_W'(w.planet_y) - OFF_W'(w.body_y);
    ax = dx < 0 ? 64'(-dx) : 64'(dx);
    ay = dy < 0 ? 64'(-dy) : 64'(dy);
    rt = floor_root(ax * ax + ay * ay);
    r.new_vx = w.body_vx;
    r.new_vy = w.body_vy;
    r.applied = 1'b0;
    if (w.body_mass == 0 || rt == 0 || rt < 64'(model_min_dist)) return r;
    den = 128'(rt) * 128'(rt) * 128'(rt);
    gm = 64'(model_grav) * 64'(w.planet_mass);
    r.new_vx = axis_velocity(w.body_vx, dx, gm, den);
    r.new_vy = axis_velocity(w.body_vy, dy, gm, den);
    r.applied = 1'b1;
    return r;
  endfunction

  function automatic in_t make_pair(int bx, int by, int vx, int vy, int bm,
                                    int px, int py, int pm);
    in_t w;
    w.body_x = bx[23:0];
    w.body_y = by[23:0];
    w.body_vx = vx[23:0];
    w.body_vy = vy[23:0];
    w.body_mass = bm[15:0];
    w.planet_x = px[23:0];
    w.planet_y = py[23:0];
    w.planet_mass = pm[15:0];
    return w;
  endfunction

  // planet near the body most of the time so the pull is exercised
  function automatic logic [POS_W-1:0] near_coord(logic [POS_W-1:0] base, bit far);
    int off;
    int c;
    if (far) return POS_W'($urandom);
    off = int'($urandom_range(0, (1 << $urandom_range(4, 20)) - 1));
    if ($urandom_range(0, 1)) off = -off;
    c = int'($signed(base)) + off;
    if (c > 8388607 || c < -8388608) c = int'($signed(base)) - off;
    return c[23:0];
  endfunction

  function automatic in_t random_pair();
    in_t w;
    bit far;
    far = $urandom_range(0, 4) == 0;
    w = in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    if (!far) begin
      w.body_x = $signed(w.body_x) >>> $urandom_range(0, 4);
      w.body_y = $signed(w.body_y) >>> $urandom_range(0, 4);
      w.body_vx = $signed(w.body_vx) >>> $urandom_range(0, 12);
      w.body_vy = $signed(w.body_vy) >>> $urandom_range(0, 12);
    end
    w.planet_x = near_coord(w.body_x, far);
    w.planet_y = near_coord(w.body_y, far);
    if ($urandom_range(0, 9) == 0) w.body_mass = 0;
    if ($urandom_range(0, 15) == 0) w.planet_mass = 0;
    if ($urandom_range(0, 3) == 0) w.planet_mass = w.planet_mass >> $urandom_range(4, 15);
    return w;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver: send queued words in bursts separated by random gaps
  always @(posedge clk) begin
    logic drive;
    if (start && !busy) begin
      velocity_q = {velocity_q, pulled_velocity(pair_q[0])};
      pair_q.pop_front();
      pairs_sent++;
    end
    drive = 1'b0;
    if (gap_left > 0) begin
      gap_left--;
    end else if (pair_q.size() > 0) begin
      drive = 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
        gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
      end
    end
    start <= drive;
    if (drive) in_data <= pair_q[0];
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    out_t exp_w;
    if (rst_n && out_valid) begin
      if (velocity_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        mismatches++;
      end else begin
        exp_w = velocity_q.pop_front();
        if (exp_w.applied) pulls_applied++;
        if (out_data.new_vx !== exp_w.new_vx) begin
          $display("%0t: new_vx expected %0d got %0d", $time, exp_w.new_vx, out_data.new_vx);
          mismatches++;
        end
        if (out_data.new_vy !== exp_w.new_vy) begin
          $display("%0t: new_vy expected %0d got %0d", $time, exp_w.new_vy, out_data.new_vy);
          mismatches++;
        end
        if (out_data.applied !== exp_w.applied) begin
          $display("%0t: applied expected %0b got %0b", $time, exp_w.applied,
                   out_data.applied);
          mismatches++;
        end
      end
    end
  end

  // watchdog: end the run when no word, result or config write has been seen for too long
  always @(posedge clk) begin
    if ((start && !busy) || (rst_n && out_valid) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired at %0t", $time);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DAT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GRAVITY) model_grav = value[GRAV_W-1:0];
    else if (idx == REG_MIN_DIST) model_min_dist = value[MIND_W-1:0];
  endtask

  task automatic drain();
    while (pair_q.size() > 0 || velocity_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    repeat (count) pair_q = {pair_q, random_pair()};
    drain();
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    pairs_sent = 0;
    pulls_applied = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    model_grav = GRAV_RESET;
    model_min_dist = MIND_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, G = 10.0, minimum 15.0
    pair_q = {pair_q, make_pair(0, 0, 1000, -1000, 0, 25600, 0, 100)};
    pair_q = {pair_q, make_pair(0, 0, 1000, -1000, 5, 2560, 0, 100)};
    pair_q = {pair_q, make_pair(0, 0, 1000, -1000, 5, 3840, 0, 100)};
    pair_q = {pair_q, make_pair(100, 200, 7, 9, 1, 3940, 3000, 0)};
    pair_q = {pair_q, make_pair(0, 0, 8388607, 8388607, 65535, 3840, 0, 65535)};
    pair_q = {pair_q, make_pair(0, 0, -8388608, -8388608, 65535, -3840, -100, 65535)};
    pair_q = {pair_q, make_pair(-8388608, -8388608, 8388607, -8388608, 65535,
                                8388607, 8388607, 65535)};
    pair_q = {pair_q, make_pair(8388607, -8388608, 0, 0, 1, -8388608, 8388607, 1)};
    pair_q = {pair_q, make_pair(5000, -7000, 123456, -654321, 77, 30000, 12000, 500)};
    drain();

    // directed: strongest G, no minimum distance
    write_reg(REG_GRAVITY, 65535);
    write_reg(REG_MIN_DIST, 0);
    pair_q = {pair_q, make_pair(1234, -4321, 55, 66, 9, 1234, -4321, 500)};
    pair_q = {pair_q, make_pair(0, 0, 0, 0, 9, 1, 0, 65535)};
    pair_q = {pair_q, make_pair(0, 0, 0, 0, 9, 0, -1, 1)};
    pair_q = {pair_q, make_pair(0, 0, 3, -3, 9, 8388607, -8388608, 1)};
    random_phase(130);

    // directed: zero G, largest minimum distance
    write_reg(REG_GRAVITY, 0);
    write_reg(REG_MIN_DIST, 8388607);
    pair_q = {pair_q, make_pair(-8388608, -8388608, 11, 22, 1, 8388607, 8388607, 65535)};
    pair_q = {pair_q, make_pair(0, 0, 11, 22, 1, 25600, 0, 65535)};
    random_phase(130);

    // back to the defaults, plus a write to an unused index that must be ignored
    write_reg(REG_GRAVITY, 2560);
    write_reg(REG_MIN_DIST, 3840);
    write_reg(REG_UNUSED, int'($urandom_range(0, 8388607)));
    random_phase(130);

    write_reg(REG_GRAVITY, int'($urandom_range(1, 65535)));
    write_reg(REG_MIN_DIST, int'($urandom_range(0, 20000)));
    random_phase(130);

    write_reg(REG_GRAVITY, 1);
    write_reg(REG_MIN_DIST, 1);
    random_phase(130);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d body-planet words, %0d with the pull applied, over six settings",
             pairs_sent, pulls_applied);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
